[src/u2u_pkg.sv]
// types and constants shared by the utf-8 to ucs decoder
package u2u_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEFT_W  = 3;
    localparam int CP_W    = 31;
    localparam int COUNT_W = 3;

    localparam logic [CP_W-1:0]    QMARK_CP   = 31'd63;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 3'd1;
    localparam logic [COUNT_W-1:0] LEN_TWO    = 3'd2;
    localparam logic [COUNT_W-1:0] LEN_THREE  = 3'd3;
    localparam logic [COUNT_W-1:0] LEN_FOUR   = 3'd4;
    localparam logic [COUNT_W-1:0] LEN_FIVE   = 3'd5;
    localparam logic [COUNT_W-1:0] LEN_SIX    = 3'd6;

    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'h1f;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'h0f;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_LEAD5 = 8'h03;
    localparam logic [BYTE_W-1:0] MASK_LEAD6 = 8'h01;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [LEFT_W-1:0] bytes_left;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [COUNT_W-1:0] byte_count;
    } out_item_t;

    typedef struct packed {
        logic [CP_W-1:0]    partial_value;
        logic [COUNT_W-1:0] bytes_pending;
        logic [COUNT_W-1:0] sequence_length;
    } dec_state_t;

endpackage

[src/utf8_to_ucs_decoder.sv]
// utf-8 to ucs decoder top level: input register, decode step, result register
//
//   channel | ports                    | payload
//   input   | s_valid s_ready s_data   | data_byte, bytes_left
//   result  | m_valid m_ready m_data   | code_point, byte_count
//
// one byte per cycle sustained while the result side keeps up; a byte waits in the input register
// and its code point is written to the result register as the byte leaves that stage
// the gathering state sits in one register updated as a byte leaves the input stage
// a byte that completes no character moves on even while the result register is full
// a held result stalls only a byte that would give a new code point
// reset clears valids and gathering state; payload registers are not reset
module utf8_to_ucs_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  u2u_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output u2u_pkg::out_item_t  m_data
);

    logic                in_valid_reg;
    logic                in_valid_next;
    u2u_pkg::in_item_t   in_data_reg;
    u2u_pkg::dec_state_t state_reg;
    u2u_pkg::dec_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    u2u_pkg::out_item_t  out_data_reg;
    u2u_pkg::out_item_t  step_result;
    logic                step_emit;
    logic                advance;

    u2u_step u_step (
        .item       (in_data_reg),
        .cur_state  (state_reg),
        .next_state (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    assign advance = in_valid_reg && (!step_emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && step_emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && step_emit) begin
            out_data_reg <= step_result;
        end
    end

`ifndef SYNTH
    // at most five continuation bytes are ever outstanding
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bytes_pending <= 3'd5)
        else $error("bytes_pending out of range");

    // an outstanding form is always longer than what is still expected
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bytes_pending != 3'd0 |->
            state_reg.sequence_length > state_reg.bytes_pending)
        else $error("sequence_length inconsistent with bytes_pending");

    // idle gathering state carries no leftover bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bytes_pending == 3'd0 |->
            state_reg.partial_value == '0 && state_reg.sequence_length == 3'd0)
        else $error("stale partial value while idle");

    // every transaction on the result side covers one to six bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg.byte_count != 3'd0 &&
            out_data_reg.byte_count != 3'd7)
        else $error("byte_count out of range");

    // a byte held by a full result register stays in the input stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage lost a stalled byte");
`endif

endmodule

[src/u2u_step.sv]
// per-byte decode: next gathering state and the optional code point
module u2u_step (
    input  u2u_pkg::in_item_t   item,
    input  u2u_pkg::dec_state_t cur_state,
    output u2u_pkg::dec_state_t next_state,
    output logic                emit,
    output u2u_pkg::out_item_t  result
);

    logic [u2u_pkg::CP_W-1:0]    shifted;
    logic [u2u_pkg::COUNT_W-1:0] lead_len;
    logic [u2u_pkg::BYTE_W-1:0]  lead_bits;
    logic [u2u_pkg::BYTE_W-1:0]  b;

    assign b       = item.data_byte;
    assign shifted = {cur_state.partial_value[u2u_pkg::CP_W-7:0], b[5:0]};

    always_comb begin
        if (b inside {[8'hc0:8'hdf]}) begin
            lead_len  = u2u_pkg::LEN_TWO;
            lead_bits = b & u2u_pkg::MASK_LEAD2;
        end else if (b inside {[8'he0:8'hef]}) begin
            lead_len  = u2u_pkg::LEN_THREE;
            lead_bits = b & u2u_pkg::MASK_LEAD3;
        end else if (b inside {[8'hf0:8'hf7]}) begin
            lead_len  = u2u_pkg::LEN_FOUR;
            lead_bits = b & u2u_pkg::MASK_LEAD4;
        end else if (b inside {[8'hf8:8'hfb]}) begin
            lead_len  = u2u_pkg::LEN_FIVE;
            lead_bits = b & u2u_pkg::MASK_LEAD5;
        end else begin
            lead_len  = u2u_pkg::LEN_SIX;
            lead_bits = b & u2u_pkg::MASK_LEAD6;
        end
    end

    always_comb begin
        next_state = cur_state;
        emit       = 1'b0;
        result     = '0;
        if (cur_state.bytes_pending != '0) begin
            next_state.partial_value = shifted;
            next_state.bytes_pending = cur_state.bytes_pending - 3'd1;
            if (cur_state.bytes_pending == 3'd1) begin
                emit                       = 1'b1;
                result.code_point          = shifted;
                result.byte_count          = cur_state.sequence_length;
                next_state.partial_value   = '0;
                next_state.sequence_length = '0;
            end
        end else if (b inside {[8'h00:8'h7f]}) begin
            emit              = 1'b1;
            result.code_point = {{(u2u_pkg::CP_W-u2u_pkg::BYTE_W){1'b0}}, b};
            result.byte_count = u2u_pkg::COUNT_ONE;
        end else if (b inside {[8'h80:8'hbf]} || item.bytes_left < lead_len) begin
            // stray continuation or form running past the string end
            emit              = 1'b1;
            result.code_point = u2u_pkg::QMARK_CP;
            result.byte_count = u2u_pkg::COUNT_ONE;
        end else begin
            next_state.partial_value   =
                {{(u2u_pkg::CP_W-u2u_pkg::BYTE_W){1'b0}}, lead_bits};
            next_state.bytes_pending   = lead_len - 3'd1;
            next_state.sequence_length = lead_len;
        end
    end

endmodule

[tb/utf8_to_ucs_decoder_test.sv]
// testbench for the utf-8 to ucs decoder: directed table, random byte strings, scoreboard
`timescale 1ns / 1ps

module utf8_to_ucs_decoder_test;

    localparam logic TYPED   = 1'b1;
    localparam logic PREDICT = 1'b0;

    typedef struct packed {
        u2u_pkg::in_item_t  stim;
        logic               typed;
        u2u_pkg::out_item_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 28;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        {8'h00, 3'd1, TYPED,   31'd0,             u2u_pkg::COUNT_ONE},
        {8'h7f, 3'd7, TYPED,   31'h7f,            u2u_pkg::COUNT_ONE},
        {8'h41, 3'd0, TYPED,   31'h41,            u2u_pkg::COUNT_ONE},
        {8'h80, 3'd6, TYPED,   u2u_pkg::QMARK_CP, u2u_pkg::COUNT_ONE},
        {8'hbf, 3'd3, TYPED,   u2u_pkg::QMARK_CP, u2u_pkg::COUNT_ONE},
        {8'hc2, 3'd0, TYPED,   u2u_pkg::QMARK_CP, u2u_pkg::COUNT_ONE},
        {8'he0, 3'd2, TYPED,   u2u_pkg::QMARK_CP, u2u_pkg::COUNT_ONE},
        {8'hfc, 3'd5, TYPED,   u2u_pkg::QMARK_CP, u2u_pkg::COUNT_ONE},
        {8'hc3, 3'd2, PREDICT, 31'd0,    3'd0},
        {8'ha9, 3'd1, PREDICT, 31'd0,    3'd0},
        {8'hef, 3'd3, PREDICT, 31'd0,    3'd0},
        {8'hff, 3'd0, PREDICT, 31'd0,    3'd0},
        {8'h00, 3'd7, PREDICT, 31'd0,    3'd0},
        {8'hf7, 3'd4, PREDICT, 31'd0,    3'd0},
        {8'hbf, 3'd3, PREDICT, 31'd0,    3'd0},
        {8'hbf, 3'd2, PREDICT, 31'd0,    3'd0},
        {8'hbf, 3'd1, PREDICT, 31'd0,    3'd0},
        {8'hfb, 3'd7, PREDICT, 31'd0,    3'd0},
        {8'h80, 3'd4, PREDICT, 31'd0,    3'd0},
        {8'h80, 3'd3, PREDICT, 31'd0,    3'd0},
        {8'h80, 3'd2, PREDICT, 31'd0,    3'd0},
        {8'h80, 3'd1, PREDICT, 31'd0,    3'd0},
        {8'hff, 3'd7, PREDICT, 31'd0,    3'd0},
        {8'hbf, 3'd6, PREDICT, 31'd0,    3'd0},
        {8'hbf, 3'd5, PREDICT, 31'd0,    3'd0},
        {8'hbf, 3'd4, PREDICT, 31'd0,    3'd0},
        {8'hbf, 3'd3, PREDICT, 31'd0,    3'd0},
        {8'hbf, 3'd2, PREDICT, 31'd0,    3'd0}
    };

    localparam int RANDOM_ITEMS = 1350;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    u2u_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    u2u_pkg::out_item_t m_data;

    logic [u2u_pkg::CP_W-1:0]    gathered_bits;
    logic [u2u_pkg::COUNT_W-1:0] cont_pending;
    logic [u2u_pkg::COUNT_W-1:0] form_length;

    u2u_pkg::out_item_t expected_cps[$];
    int                 error_count;
    int                 bytes_sent;

    utf8_to_ucs_decoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic decode_byte(input u2u_pkg::in_item_t it,
                                         output u2u_pkg::out_item_t cp);
        logic [u2u_pkg::COUNT_W-1:0] len;
        logic [u2u_pkg::BYTE_W-1:0]  lead_bits;
        cp = '0;
        if (cont_pending != 0) begin
            gathered_bits = {gathered_bits[u2u_pkg::CP_W-7:0], it.data_byte[5:0]};
            cont_pending  = cont_pending - 1'b1;
            if (cont_pending != 0) return 1'b0;
            cp.code_point = gathered_bits;
            cp.byte_count = form_length;
            gathered_bits = '0;
            form_length   = '0;
            return 1'b1;
        end
        if (it.data_byte < 8'h80) begin
            cp.code_point = u2u_pkg::CP_W'(it.data_byte);
            cp.byte_count = u2u_pkg::COUNT_ONE;
            return 1'b1;
        end
        if (it.data_byte < 8'hc0) begin
            cp.code_point = u2u_pkg::QMARK_CP;
            cp.byte_count = u2u_pkg::COUNT_ONE;
            return 1'b1;
        end
        if (it.data_byte < 8'he0) begin
            len = u2u_pkg::LEN_TWO;   lead_bits = it.data_byte & u2u_pkg::MASK_LEAD2;
        end else if (it.data_byte < 8'hf0) begin
            len = u2u_pkg::LEN_THREE; lead_bits = it.data_byte & u2u_pkg::MASK_LEAD3;
        end else if (it.data_byte < 8'hf8) begin
            len = u2u_pkg::LEN_FOUR;  lead_bits = it.data_byte & u2u_pkg::MASK_LEAD4;
        end else if (it.data_byte < 8'hfc) begin
            len = u2u_pkg::LEN_FIVE;  lead_bits = it.data_byte & u2u_pkg::MASK_LEAD5;
        end else begin
            len = u2u_pkg::LEN_SIX;   lead_bits = it.data_byte & u2u_pkg::MASK_LEAD6;
        end
        if (it.bytes_left < len) begin
            cp.code_point = u2u_pkg::QMARK_CP;
            cp.byte_count = u2u_pkg::COUNT_ONE;
            return 1'b1;
        end
        gathered_bits = u2u_pkg::CP_W'(lead_bits);
        cont_pending  = len - 1'b1;
        form_length   = len;
        return 1'b0;
    endfunction

    task automatic send_byte(input u2u_pkg::in_item_t it, input logic typed,
                             input u2u_pkg::out_item_t want, input logic burst);
        int                 gap;
        u2u_pkg::out_item_t cp;
        logic               has_cp;
        gap = burst ? 0 : int'($urandom_range(0, 13));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        has_cp = decode_byte(it, cp);
        if (typed) expected_cps.push_back(want);
        else if (has_cp) expected_cps.push_back(cp);
        bytes_sent++;
    endtask

    task automatic check_result(input u2u_pkg::out_item_t got);
        u2u_pkg::out_item_t want;
        if (expected_cps.size() == 0) begin
            $error("unexpected code_point %0h byte_count %0d", got.code_point, got.byte_count);
            error_count++;
            return;
        end
        want = expected_cps.pop_front();
        if (got.code_point !== want.code_point) begin
            $error("code_point expected %0h actual %0h", want.code_point, got.code_point);
            error_count++;
        end
        if (got.byte_count !== want.byte_count) begin
            $error("byte_count expected %0d actual %0d", want.byte_count, got.byte_count);
            error_count++;
        end
    endtask

    // one form with random content, its continuation bytes sometimes replaced by noise, or a single noise byte
    task automatic build_string(ref u2u_pkg::in_item_t seq[$]);
        u2u_pkg::in_item_t it;
        int                len;
        seq.delete();
        if ($urandom_range(0, 4) == 0) begin
            it.data_byte  = 8'($urandom_range(0, 255));
            it.bytes_left = 3'($urandom_range(0, 7));
            seq.push_back(it);
            return;
        end
        len = int'($urandom_range(1, 6));
        case (len)
            1: it.data_byte = 8'($urandom_range(0, 127));
            2: it.data_byte = 8'hc0 | 8'($urandom_range(0, 31));
            3: it.data_byte = 8'he0 | 8'($urandom_range(0, 15));
            4: it.data_byte = 8'hf0 | 8'($urandom_range(0, 7));
            5: it.data_byte = 8'hf8 | 8'($urandom_range(0, 3));
            default: it.data_byte = 8'hfc | 8'($urandom_range(0, 3));
        endcase
        it.bytes_left = (len == 1) ? 3'($urandom_range(0, 7))
                                   : 3'($urandom_range(len, 7));
        seq.push_back(it);
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) it.data_byte = 8'($urandom_range(0, 255));
            else it.data_byte = {2'b10, 6'($urandom_range(0, 63))};
            it.bytes_left = 3'($urandom_range(0, 7));
            seq.push_back(it);
        end
    endtask

    initial begin
        int stall;
        logic burst;
        burst = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0) burst = !burst;
            stall = burst ? 0 : int'($urandom_range(0, 13));
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && aresetn)) @(posedge aclk);
            check_result(m_data);
        end
    end

    initial begin
        u2u_pkg::in_item_t seq[$];
        logic              burst;
        error_count   = 0;
        bytes_sent    = 0;
        burst         = 1'b0;
        gathered_bits = '0;
        cont_pending  = '0;
        form_length   = '0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(DIRECTED[r].stim, DIRECTED[r].typed, DIRECTED[r].want, 1'b0);

        while (bytes_sent < DIR_ROWS + RANDOM_ITEMS) begin
            build_string(seq);
            foreach (seq[i]) begin
                if ($urandom_range(0, 39) == 0) burst = !burst;
                send_byte(seq[i], PREDICT, '0, burst);
            end
        end
        s_valid <= 1'b0;

        while (expected_cps.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
